// ===== rtl/core/btd_pkg.sv =====
package btd_pkg;

	localparam int VALUE_W    = 11;
	localparam int SEG_W      = 7;
	localparam int CODE_W     = 4;
	localparam int COUNT_W    = 7;
	localparam int MAG_W      = 10;
	localparam int REM_W      = 7;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 4;

	// register indexes on the configuration port
	localparam logic [CFG_IDX_W-1:0] REG_FLASH_RATE = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_START_ON   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DP_POS     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SHORT_OFF  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_BLANK_OFF  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_RECALC     = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_BLINK_MASK = 3'd6;

	typedef logic [CODE_W-1:0] digit_t;

	typedef struct packed {
		digit_t hun;
		digit_t ten;
		digit_t one;
	} digits_t;

	localparam digit_t CODE_P     = 4'd10;
	localparam digit_t CODE_MINUS = 4'd14;

	function automatic logic [SEG_W-1:0] btd_seg(input digit_t code);
		logic [SEG_W-1:0] s;
		case (code)
			4'd0:    s = 7'h3f;
			4'd1:    s = 7'h06;
			4'd2:    s = 7'h5b;
			4'd3:    s = 7'h4f;
			4'd4:    s = 7'h66;
			4'd5:    s = 7'h6d;
			4'd6:    s = 7'h7d;
			4'd7:    s = 7'h07;
			4'd8:    s = 7'h7f;
			4'd9:    s = 7'h6f;
			4'd10:   s = 7'h73;
			4'd11:   s = 7'h79;
			4'd12:   s = 7'h71;
			4'd13:   s = 7'h50;
			4'd14:   s = 7'h40;
			default: s = 7'h00;
		endcase
		return s;
	endfunction

	// blink limit: 100 / rate, zero when blinking is off
	function automatic logic [COUNT_W-1:0] btd_limit(input logic [3:0] rate);
		logic [COUNT_W-1:0] l;
		case (rate)
			4'd1:    l = 7'd100;
			4'd2:    l = 7'd50;
			4'd3:    l = 7'd33;
			4'd4:    l = 7'd25;
			4'd5:    l = 7'd20;
			4'd6:    l = 7'd16;
			4'd7:    l = 7'd14;
			4'd8:    l = 7'd12;
			4'd9:    l = 7'd11;
			4'd10:   l = 7'd10;
			4'd11:   l = 7'd9;
			4'd12:   l = 7'd8;
			4'd13:   l = 7'd7;
			4'd14:   l = 7'd7;
			4'd15:   l = 7'd6;
			default: l = 7'd0;
		endcase
		return l;
	endfunction

endpackage

// ===== rtl/core/btd_if.sv =====
interface btd_tick_if;
	logic                                valid;
	logic                                ready;
	logic signed [btd_pkg::VALUE_W-1:0]  value;
	logic                                setting_mode;

	modport source (output valid, output value, output setting_mode, input ready);
	modport sink   (input valid, input value, input setting_mode, output ready);
endinterface

interface btd_disp_if;
	logic                          valid;
	logic                          ready;
	logic [btd_pkg::SEG_W-1:0]     seg_hundreds;
	logic [btd_pkg::SEG_W-1:0]     seg_tens;
	logic [btd_pkg::SEG_W-1:0]     seg_ones;
	logic                          show_hundreds;
	logic                          show_tens;
	logic                          show_ones;
	logic                          dp_hundreds;
	logic                          dp_tens;
	logic                          dp_ones;

	modport source (
		output valid, output seg_hundreds, output seg_tens, output seg_ones,
		output show_hundreds, output show_tens, output show_ones,
		output dp_hundreds, output dp_tens, output dp_ones, input ready
	);
	modport sink (
		input valid, input seg_hundreds, input seg_tens, input seg_ones,
		input show_hundreds, input show_tens, input show_ones,
		input dp_hundreds, input dp_tens, input dp_ones, output ready
	);
endinterface

// ===== rtl/core/blinking_three_digit_display.sv =====
// Three-digit blinking seven-segment display driver.
// tick (sink): one beat per refresh tick, carrying the signed value to show
//   and the setting-mode flag. disp (source): one beat per tick with segment
//   patterns, per-digit show flags and decimal point flags.
// cfg_we/cfg_index/cfg_data: register writes, taken on any edge with cfg_we
//   high; every write to a known register restarts the blink sequence. The user
//   must issue writes only while no tick is in flight; the block does not check.
// Pipeline: a tick accepted at one edge is captured in the input register and
//   its result is loaded into the output register once that register is empty
//   or disp.ready is high, raising disp valid. One tick per cycle is sustained
//   while disp.ready is high; the blink counter and digit store update in the
//   single pass between the input and output registers.
// Stall: while disp.ready is low the result is held; the input register still
//   takes one more beat, after which tick.ready drops until the result drains.
// Reset: the control and state registers take their defaults (blinking off,
//   phase lit, decimal point off, digits recomputed each tick, stored digits
//   000); no beats are in flight after reset. Data registers are not reset.
module blinking_three_digit_display (
	input  logic                               clk,
	input  logic                               arst_n,
	btd_tick_if.sink                           tick,
	btd_disp_if.source                         disp,
	input  logic                               cfg_we,
	input  logic [btd_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [btd_pkg::CFG_DATA_W-1:0]     cfg_data
);
	import btd_pkg::*;

	// configuration
	logic [3:0] flash_rate_q;
	logic       start_on_q;
	logic [1:0] dp_position_q;
	logic       short_off_q;
	logic       blank_off_q;
	logic       recalc_q;
	logic [2:0] blink_mask_q;

	logic [3:0] rate_n;
	logic       start_n;
	logic [1:0] dp_n;
	logic       short_n;
	logic       blank_n;
	logic       recalc_n;
	logic [2:0] mask_n;
	logic       cfg_hit;
	logic [COUNT_W-1:0] limit_cfg;
	logic [COUNT_W-1:0] count_cfg;

	// blink state and digit store
	logic [COUNT_W-1:0] blink_count_q;
	logic [COUNT_W-1:0] blink_limit_q;
	logic               lit_q;
	digits_t            digits_q;

	// input stage
	logic                      valid_s1;
	logic signed [VALUE_W-1:0] value_s1;
	logic                      setting_s1;

	// output stage
	logic              out_valid_q;
	logic [SEG_W-1:0]  seg_h_q, seg_t_q, seg_o_q;
	logic [2:0]        show_q;
	logic [2:0]        dp_q;

	logic               advance;
	logic [COUNT_W-1:0] cnt_inc;
	logic [COUNT_W-1:0] cnt_dec;
	logic [COUNT_W-1:0] count_n;
	logic               lit_n;
	logic               blank_tick;
	digits_t            split_digits;
	digits_t            digits_n;
	logic [2:0]         show_n;
	logic [2:0]         dp_n3;
	logic [SEG_W-1:0]   seg_h_n, seg_t_n, seg_o_n;

	btd_split u_split (
		.value        (value_s1),
		.setting_mode (setting_s1),
		.digits       (split_digits)
	);

	assign advance    = valid_s1 && (!out_valid_q || disp.ready);
	assign tick.ready = !valid_s1 || advance;

	// register write decode
	assign cfg_hit = cfg_we && (cfg_index inside {[REG_FLASH_RATE:REG_BLINK_MASK]});

	always_comb begin
		rate_n   = flash_rate_q;
		start_n  = start_on_q;
		dp_n     = dp_position_q;
		short_n  = short_off_q;
		blank_n  = blank_off_q;
		recalc_n = recalc_q;
		mask_n   = blink_mask_q;
		case (cfg_index)
			REG_FLASH_RATE: rate_n   = cfg_data[3:0];
			REG_START_ON:   start_n  = cfg_data[0];
			REG_DP_POS:     dp_n     = cfg_data[1:0];
			REG_SHORT_OFF:  short_n  = cfg_data[0];
			REG_BLANK_OFF:  blank_n  = cfg_data[0];
			REG_RECALC:     recalc_n = cfg_data[0];
			REG_BLINK_MASK: mask_n   = cfg_data[2:0];
			default: ;
		endcase
	end

	// restart of the blink sequence, from the freshly written values
	assign limit_cfg = btd_limit(rate_n);
	always_comb begin
		count_cfg = '0;
		if (rate_n != 4'd0 && !start_n)
			count_cfg = short_n ? (limit_cfg >> 2) : limit_cfg;
	end

	// per-tick blink step
	assign cnt_inc = blink_count_q + 7'd1;
	assign cnt_dec = (blink_count_q != '0) ? blink_count_q - 7'd1 : blink_count_q;

	always_comb begin
		count_n    = blink_count_q;
		lit_n      = lit_q;
		blank_tick = 1'b0;
		if (blink_limit_q != '0) begin
			if (lit_q) begin
				count_n = cnt_inc;
				if (cnt_inc == blink_limit_q) begin
					lit_n = 1'b0;
					if (short_off_q)
						count_n = cnt_inc >> 2;
				end
			end else begin
				count_n = cnt_dec;
				if (cnt_dec == '0)
					lit_n = 1'b1;
				blank_tick = blank_off_q;
			end
		end
	end

	always_comb begin
		digits_n = digits_q;
		if (!blank_tick && recalc_q)
			digits_n = split_digits;
	end

	// bit 2 hundreds, bit 1 tens, bit 0 ones
	always_comb begin
		for (int d = 0; d < 3; d++) begin
			show_n[d] = !blank_tick && (lit_n || !blink_mask_q[d]);
			dp_n3[d]  = show_n[d] && (dp_position_q == 2'(d + 1));
		end
		seg_h_n = show_n[2] ? btd_seg(digits_n.hun) : '0;
		seg_t_n = show_n[1] ? btd_seg(digits_n.ten) : '0;
		seg_o_n = show_n[0] ? btd_seg(digits_n.one) : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flash_rate_q  <= '0;
			start_on_q    <= 1'b1;
			dp_position_q <= '0;
			short_off_q   <= 1'b0;
			blank_off_q   <= 1'b0;
			recalc_q      <= 1'b1;
			blink_mask_q  <= '0;
			blink_count_q <= '0;
			blink_limit_q <= '0;
			lit_q         <= 1'b1;
			digits_q      <= '0;
			valid_s1      <= 1'b0;
			out_valid_q   <= 1'b0;
		end else begin
			if (cfg_hit) begin
				flash_rate_q  <= rate_n;
				start_on_q    <= start_n;
				dp_position_q <= dp_n;
				short_off_q   <= short_n;
				blank_off_q   <= blank_n;
				recalc_q      <= recalc_n;
				blink_mask_q  <= mask_n;
				blink_limit_q <= limit_cfg;
				blink_count_q <= count_cfg;
				lit_q         <= start_n;
			end else if (advance) begin
				blink_count_q <= count_n;
				lit_q         <= lit_n;
				digits_q      <= digits_n;
			end
			if (tick.ready)
				valid_s1 <= tick.valid;
			if (advance)
				out_valid_q <= 1'b1;
			else if (disp.ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (tick.valid && tick.ready) begin
			value_s1   <= tick.value;
			setting_s1 <= tick.setting_mode;
		end
		if (advance) begin
			seg_h_q <= seg_h_n;
			seg_t_q <= seg_t_n;
			seg_o_q <= seg_o_n;
			show_q  <= show_n;
			dp_q    <= dp_n3;
		end
	end

	assign disp.valid         = out_valid_q;
	assign disp.seg_hundreds  = seg_h_q;
	assign disp.seg_tens      = seg_t_q;
	assign disp.seg_ones      = seg_o_q;
	assign disp.show_hundreds = show_q[2];
	assign disp.show_tens     = show_q[1];
	assign disp.show_ones     = show_q[0];
	assign disp.dp_hundreds   = dp_q[2];
	assign disp.dp_tens       = dp_q[1];
	assign disp.dp_ones       = dp_q[0];

	a_limit_follows_rate: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_hit |=> blink_limit_q == btd_limit(flash_rate_q))
		else $error("blink limit does not match flash rate after write");

	a_count_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		blink_count_q <= blink_limit_q)
		else $error("blink count beyond limit");

	a_hidden_digit_dark: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !show_q[2] |-> seg_h_q == '0 && !dp_q[2])
		else $error("hidden hundreds digit drives segments");

	a_single_dp: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> $onehot0(dp_q))
		else $error("more than one decimal point lit");

endmodule

// ===== rtl/core/btd_split.sv =====
module btd_split (
	input  logic signed [btd_pkg::VALUE_W-1:0] value,
	input  logic                               setting_mode,
	output btd_pkg::digits_t                   digits
);
	import btd_pkg::*;

	logic [VALUE_W-1:0] neg_value;
	logic [MAG_W-1:0]   mag;
	logic [CODE_W-1:0]  hun_cnt;
	logic [REM_W-1:0]   rem;
	logic [CODE_W-1:0]  ten_cnt;
	logic [CODE_W-1:0]  one_val;
	logic [MAG_W-1:0]   hun_sub;
	logic [REM_W-1:0]   ten_sub;

	assign neg_value = VALUE_W'(-value);

	// clamp to the displayable range and take the magnitude
	always_comb begin
		mag = value[MAG_W-1:0];
		if (setting_mode) begin
			if (value < 0)
				mag = '0;
			else if (value > 11'sd99)
				mag = 10'd99;
		end else begin
			if (value < -11'sd99)
				mag = 10'd99;
			else if (value < 0)
				mag = neg_value[MAG_W-1:0];
			else if (value > 11'sd999)
				mag = 10'd999;
		end
	end

	// hundreds and tens by threshold counting
	always_comb begin
		hun_cnt = '0;
		for (int k = 1; k <= 9; k++) begin
			if (mag >= MAG_W'(k * 100))
				hun_cnt = hun_cnt + 4'd1;
		end
	end

	assign hun_sub = MAG_W'(hun_cnt) * 10'd100;
	assign rem     = REM_W'(mag - hun_sub);

	always_comb begin
		ten_cnt = '0;
		for (int k = 1; k <= 9; k++) begin
			if (rem >= REM_W'(k * 10))
				ten_cnt = ten_cnt + 4'd1;
		end
	end

	assign ten_sub = REM_W'(ten_cnt) * 7'd10;
	assign one_val = CODE_W'(rem - ten_sub);

	always_comb begin
		if (setting_mode)
			digits.hun = CODE_P;
		else if (value < 0)
			digits.hun = CODE_MINUS;
		else
			digits.hun = hun_cnt;
		digits.ten = ten_cnt;
		digits.one = one_val;
	end

endmodule
